// ----- sv/agc_pkg.sv -----
// agc_pkg: shared types and constants for the hang/attack AGC block.
// Holds the controller state, datapath command/status structs and reset values.
// No dependencies.
package agc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int LVL_W    = 15;
    localparam int RATE_W   = 16;
    localparam int CNT_W    = 15;
    localparam int GAIN_W   = 33;
    localparam int ALPHA_W  = 17;
    localparam int QUO_W    = 31;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = 50;
    localparam int DIVC_W   = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(QUO_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_REF_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HANG      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd6;

    localparam logic [LVL_W-1:0]   RST_REF_LEVEL = 15'd6554;
    localparam logic [RATE_W-1:0]  RST_ATTACK    = 16'd655;
    localparam logic [RATE_W-1:0]  RST_DECAY     = 16'd7;
    localparam logic [GAIN_W-1:0]  RST_MAX_GAIN  = 33'h1_0000_0000;
    localparam logic [CNT_W-1:0]   RST_HANG      = 15'd200;
    localparam logic [CNT_W-1:0]   RST_WAIT      = 15'd0;
    localparam logic [ALPHA_W-1:0] RST_ALPHA     = 17'd65470;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 33'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_TOP  = 33'h1_0000_0000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_MSTEP,
        ST_MFILT,
        ST_MOUT
    } t_state;

    typedef enum logic [1:0] {
        MS_STEP,
        MS_FILT,
        MS_OUT
    } t_mul_sel;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SUM
    } t_mul_phase;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     decide;
        logic     apply;
        logic     filt;
        logic     out_write;
        logic     mul_start;
        t_mul_sel mul_sel;
    } t_cmd;

    typedef struct packed {
        logic mag_zero;
        logic mul_done;
    } t_stat;

endpackage

// ----- sv/agc_mul.sv -----
// agc_mul: shared 33x17 unsigned multiplier, two 17x17 partial products.
// Operands are read live during the LO and HI phases; product held until next start.
// Depends on agc_pkg.
module agc_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [agc_pkg::MUL_A_W-1:0]   i_a,
    input  logic [agc_pkg::MUL_B_W-1:0]   i_b,
    output logic                          o_done,
    output logic [agc_pkg::PROD_W-1:0]    o_p
);

    agc_pkg::t_mul_phase r_phase, n_phase;
    logic        r_done;
    logic [33:0] r_lo;
    logic [32:0] r_hi;
    logic [agc_pkg::PROD_W-1:0] r_p;
    logic [16:0] mop;
    logic [33:0] prod;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            agc_pkg::MP_IDLE: if (i_start) n_phase = agc_pkg::MP_LO;
            agc_pkg::MP_LO:   n_phase = agc_pkg::MP_HI;
            agc_pkg::MP_HI:   n_phase = agc_pkg::MP_SUM;
            agc_pkg::MP_SUM:  n_phase = agc_pkg::MP_IDLE;
            default:          n_phase = agc_pkg::MP_IDLE;
        endcase
    end

    assign mop  = (r_phase == agc_pkg::MP_LO) ? i_a[16:0] : {1'b0, i_a[32:17]};
    assign prod = {17'd0, mop} * {17'd0, i_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= agc_pkg::MP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (r_phase == agc_pkg::MP_IDLE && i_start) begin
                r_done <= 1'b0;
            end else if (r_phase == agc_pkg::MP_SUM) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == agc_pkg::MP_LO) begin
            r_lo <= prod;
        end
        if (r_phase == agc_pkg::MP_HI) begin
            r_hi <= prod[32:0];
        end
        if (r_phase == agc_pkg::MP_SUM) begin
            r_p <= {16'd0, r_lo} + {r_hi, 17'd0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ----- sv/agc_dp.sv -----
// agc_dp: AGC datapath - config registers, gain/peak/hang/wait state,
// bit-serial divider, step/filter/output arithmetic. Depends on agc_pkg, agc_mul.
module agc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  agc_pkg::t_cmd                    i_cmd,
    output agc_pkg::t_stat                   o_stat,
    input  logic                             i_cfg_we,
    input  logic [agc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [agc_pkg::GAIN_W-1:0]       i_cfg_data,
    input  logic signed [agc_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic signed [agc_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic [agc_pkg::GAIN_W-1:0]       o_gain_now
);

    // config
    logic [agc_pkg::LVL_W-1:0]   r_cfg_ref;
    logic [agc_pkg::RATE_W-1:0]  r_cfg_attack;
    logic [agc_pkg::RATE_W-1:0]  r_cfg_decay;
    logic [agc_pkg::GAIN_W-1:0]  r_cfg_max;
    logic [agc_pkg::CNT_W-1:0]   r_cfg_hang;
    logic [agc_pkg::CNT_W-1:0]   r_cfg_wait;
    logic [agc_pkg::ALPHA_W-1:0] r_cfg_alpha;

    // state
    logic [agc_pkg::GAIN_W-1:0]  r_gain_reg;
    logic [agc_pkg::MAG_W-1:0]   r_peak;
    logic [agc_pkg::CNT_W-1:0]   r_hang;
    logic [agc_pkg::CNT_W-1:0]   r_wait;

    // per-word working registers
    logic                        r_sign;
    logic [agc_pkg::MAG_W-1:0]   r_mag;
    logic [agc_pkg::MAG_W-1:0]   r_rem;
    logic [agc_pkg::QUO_W-1:0]   r_dq;
    logic                        r_err_neg;
    logic [agc_pkg::GAIN_W-1:0]  r_err_mag;
    logic [agc_pkg::RATE_W-1:0]  r_rate;
    logic                        r_step_en;
    logic [agc_pkg::GAIN_W-1:0]  r_gain_c;
    logic signed [agc_pkg::SAMPLE_W-1:0] r_sample_out;
    logic [agc_pkg::GAIN_W-1:0]  r_gain_now;

    logic [agc_pkg::MAG_W-1:0]   in_mag;
    logic [16:0]                 div_t;
    logic                        div_ge;
    logic [16:0]                 div_r;

    logic signed [34:0]          err;
    logic                        err_neg;
    logic [34:0]                 err_abs;
    logic                        new_peak;
    logic [agc_pkg::CNT_W-1:0]   wait_eff;
    logic [agc_pkg::MAG_W-1:0]   d_peak;
    logic [agc_pkg::CNT_W-1:0]   d_wait;
    logic [agc_pkg::CNT_W-1:0]   d_hang;
    logic                        d_step_en;
    logic [agc_pkg::RATE_W-1:0]  d_rate;

    logic [agc_pkg::PROD_W-1:0]  mul_rnd;
    logic [33:0]                 step_mag;
    logic signed [35:0]          gain_s;
    logic [agc_pkg::GAIN_W-1:0]  gain_c;

    logic [agc_pkg::ALPHA_W-1:0] alpha_eff;
    logic [agc_pkg::ALPHA_W-1:0] coef;
    logic [33:0]                 g_sum;
    logic [agc_pkg::GAIN_W-1:0]  g_new;

    logic [33:0]                 q;
    logic [agc_pkg::SAMPLE_W-1:0] out_v;

    logic [agc_pkg::MUL_A_W-1:0] mul_a;
    logic [agc_pkg::MUL_B_W-1:0] mul_b;
    logic                        mul_done;
    logic [agc_pkg::PROD_W-1:0]  mul_p;

    agc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign in_mag = i_sample_in[15] ? (16'd0 - i_sample_in) : i_sample_in;

    // restoring divide, one quotient bit per step
    assign div_t  = {r_rem, r_dq[agc_pkg::QUO_W-1]};
    assign div_ge = div_t >= {1'b0, r_mag};
    assign div_r  = div_ge ? (div_t - {1'b0, r_mag}) : div_t;

    // error and counter decisions
    assign err     = $signed({4'd0, r_dq}) - $signed({2'd0, r_gain_reg});
    assign err_neg = err[34];
    assign err_abs = err_neg ? (35'd0 - err) : err;
    assign new_peak = r_peak < r_mag;
    assign wait_eff = new_peak ? r_cfg_wait : r_wait;

    always_comb begin
        d_peak    = r_peak;
        d_wait    = r_wait;
        d_hang    = r_hang;
        d_step_en = 1'b0;
        d_rate    = r_cfg_decay;
        if (err_neg) begin
            if (new_peak) begin
                d_peak = r_mag;
            end
            if (wait_eff != '0) begin
                d_wait = wait_eff - 1'b1;
            end else begin
                d_wait    = wait_eff;
                d_step_en = 1'b1;
                d_rate    = r_cfg_attack;
                d_hang    = r_cfg_hang;
            end
        end else begin
            if (r_hang != '0) begin
                d_hang = r_hang - 1'b1;
            end else begin
                d_step_en = 1'b1;
            end
        end
    end

    // step, floor toward minus infinity, then clamp
    assign mul_rnd  = mul_p + agc_pkg::PROD_W'(16'hFFFF);
    assign step_mag = r_err_neg ? mul_rnd[49:16] : mul_p[49:16];

    always_comb begin
        if (!r_step_en) begin
            gain_s = $signed({3'd0, r_gain_reg});
        end else if (r_err_neg) begin
            gain_s = $signed({3'd0, r_gain_reg}) - $signed({2'd0, step_mag});
        end else begin
            gain_s = $signed({3'd0, r_gain_reg}) + $signed({2'd0, step_mag});
        end
        if (gain_s[35]) begin
            gain_c = '0;
        end else if (gain_s[34:0] > {2'd0, r_cfg_max}) begin
            gain_c = r_cfg_max;
        end else begin
            gain_c = gain_s[32:0];
        end
    end

    // smoothing filter
    assign alpha_eff = (r_cfg_alpha > agc_pkg::ALPHA_ONE) ? agc_pkg::ALPHA_ONE : r_cfg_alpha;
    assign coef      = agc_pkg::ALPHA_ONE - alpha_eff;
    assign g_sum     = {1'b0, r_gain_c} + mul_p[49:16];
    assign g_new     = (g_sum > {1'b0, agc_pkg::GAIN_TOP}) ? agc_pkg::GAIN_TOP : g_sum[32:0];

    // output scaling and saturation
    assign q = mul_p[49:16];
    always_comb begin
        if (r_sign) begin
            out_v = (q > 34'd32768) ? 16'h8000 : (16'd0 - q[15:0]);
        end else begin
            out_v = (q > 34'd32767) ? 16'h7FFF : q[15:0];
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            agc_pkg::MS_STEP: begin
                mul_a = r_err_mag;
                mul_b = {1'b0, r_rate};
            end
            agc_pkg::MS_FILT: begin
                mul_a = r_gain_reg;
                mul_b = coef;
            end
            agc_pkg::MS_OUT: begin
                mul_a = r_gain_reg;
                mul_b = {1'b0, r_mag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ref    <= agc_pkg::RST_REF_LEVEL;
            r_cfg_attack <= agc_pkg::RST_ATTACK;
            r_cfg_decay  <= agc_pkg::RST_DECAY;
            r_cfg_max    <= agc_pkg::RST_MAX_GAIN;
            r_cfg_hang   <= agc_pkg::RST_HANG;
            r_cfg_wait   <= agc_pkg::RST_WAIT;
            r_cfg_alpha  <= agc_pkg::RST_ALPHA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                agc_pkg::CFG_REF_LEVEL: r_cfg_ref    <= i_cfg_data[14:0];
                agc_pkg::CFG_ATTACK:    r_cfg_attack <= i_cfg_data[15:0];
                agc_pkg::CFG_DECAY:     r_cfg_decay  <= i_cfg_data[15:0];
                agc_pkg::CFG_MAX_GAIN:  r_cfg_max    <= i_cfg_data;
                agc_pkg::CFG_HANG:      r_cfg_hang   <= i_cfg_data[14:0];
                agc_pkg::CFG_WAIT:      r_cfg_wait   <= i_cfg_data[14:0];
                agc_pkg::CFG_ALPHA:     r_cfg_alpha  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_reg <= agc_pkg::GAIN_ONE;
            r_peak     <= '0;
            r_hang     <= '0;
            r_wait     <= '0;
        end else begin
            if (i_cmd.decide) begin
                r_peak <= d_peak;
                r_hang <= d_hang;
                r_wait <= d_wait;
            end
            if (i_cmd.filt) begin
                r_gain_reg <= g_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sign    <= i_sample_in[15];
            r_mag     <= in_mag;
            r_rem     <= '0;
            r_dq      <= {r_cfg_ref, 16'd0};
            r_step_en <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_r[15:0];
            r_dq  <= {r_dq[agc_pkg::QUO_W-2:0], div_ge};
        end
        if (i_cmd.decide) begin
            r_err_neg <= err_neg;
            r_err_mag <= err_abs[32:0];
            r_rate    <= d_rate;
            r_step_en <= d_step_en;
        end
        if (i_cmd.apply) begin
            r_gain_c <= gain_c;
        end
        if (i_cmd.out_write) begin
            r_sample_out <= out_v;
            r_gain_now   <= r_gain_reg;
        end
    end

    assign o_stat.mag_zero = (r_mag == '0);
    assign o_stat.mul_done = mul_done;
    assign o_sample_out    = r_sample_out;
    assign o_gain_now      = r_gain_now;

endmodule

// ----- sv/agc_ctrl.sv -----
// agc_ctrl: AGC sequencer - input/output handshakes, divide step count,
// multiplier hand-offs. Depends on agc_pkg.
module agc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output agc_pkg::t_cmd  o_cmd,
    input  agc_pkg::t_stat i_stat
);

    agc_pkg::t_state r_state, n_state;
    logic [agc_pkg::DIVC_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= agc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            agc_pkg::ST_MFILT: o_cmd.mul_sel = agc_pkg::MS_FILT;
            agc_pkg::ST_MOUT:  o_cmd.mul_sel = agc_pkg::MS_OUT;
            default:           o_cmd.mul_sel = agc_pkg::MS_STEP;
        endcase

        unique case (r_state)
            agc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = agc_pkg::ST_DIV;
                end
            end
            agc_pkg::ST_DIV: begin
                if (i_stat.mag_zero) begin
                    o_cmd.apply     = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = agc_pkg::ST_MFILT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (r_cnt == agc_pkg::DIV_LAST) begin
                        n_state = agc_pkg::ST_DECIDE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            agc_pkg::ST_DECIDE: begin
                o_cmd.decide    = 1'b1;
                o_cmd.mul_start = 1'b1;
                n_state         = agc_pkg::ST_MSTEP;
            end
            agc_pkg::ST_MSTEP: begin
                if (i_stat.mul_done) begin
                    o_cmd.apply     = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = agc_pkg::ST_MFILT;
                end
            end
            agc_pkg::ST_MFILT: begin
                if (i_stat.mul_done) begin
                    o_cmd.filt      = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = agc_pkg::ST_MOUT;
                end
            end
            agc_pkg::ST_MOUT: begin
                if (i_stat.mul_done && (!r_out_valid || i_out_ready)) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = agc_pkg::ST_IDLE;
                end
            end
            default: n_state = agc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_write) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/audio_agc_hang_attack.sv -----
// audio_agc_hang_attack: automatic gain control with hang and attack wait.
// Input channel: i_in_valid/o_in_ready with i_sample_in (signed Q1.15). One word in
// gives one word out: o_sample_out (gain*x, saturated Q1.15) and o_gain_now (Q17.16).
// Config channel: i_cfg_valid/o_cfg_ready, i_cfg_index selects the register
// (0 reference, 1 attack rate, 2 decay rate, 3 max gain, 4 hang, 5 attack wait,
// 6 filter alpha); o_cfg_ready is always high. Write only while idle.
// Processing: a nonzero sample goes through the 31-step bit-serial divide of
// reference by |x|, then three passes through the shared 33x17 multiplier (step,
// filter, output). A zero sample skips the divide and the step pass.
// A new word is taken only once the current one has been written to the output
// register; one word is in flight at a time.
// The result sits in an output register; the next word is accepted and worked on
// while it waits. If the receiver stalls, the block parks before writing the output
// register until it frees up.
// Reset (synchronous, active low) restores the register defaults, gain 1.0 and
// clears peak, hang and wait counters; no output is pending after reset.
// Depends on agc_pkg, agc_ctrl, agc_dp.
module audio_agc_hang_attack (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [agc_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [agc_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic [agc_pkg::GAIN_W-1:0]        o_gain_now,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [agc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [agc_pkg::GAIN_W-1:0]        i_cfg_data
);

    agc_pkg::t_cmd  cmd;
    agc_pkg::t_stat stat;
    logic           cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    agc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    agc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_gain_now   (o_gain_now)
    );

endmodule

// ----- sv/agc_chk.sv -----
// agc_chk: port-level checks for audio_agc_hang_attack, bound to the top level.
// Depends on agc_pkg.
module agc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic signed [agc_pkg::SAMPLE_W-1:0] i_sample_in,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [agc_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic [agc_pkg::GAIN_W-1:0]        o_gain_now,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [agc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [agc_pkg::GAIN_W-1:0]        i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sample_out) && $stable(o_gain_now))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready while a word is in progress");

    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a word in progress");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_gain_now[32] || o_gain_now[31:0] == 32'd0))
        else $error("reported gain above 65536.0");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_gain_now == 33'd0 |-> o_sample_out == 16'sd0)
        else $error("nonzero output at zero gain");

endmodule

bind audio_agc_hang_attack agc_chk u_agc_chk (.*);

// ----- tb/tb_audio_agc_hang_attack.sv -----
// tb_audio_agc_hang_attack: self-checking testbench for the hang/attack AGC block.
// Runs directed and random sample streams under changing settings against a built-in predictor.
// Depends on agc_pkg and audio_agc_hang_attack.
`timescale 1ns / 1ps

module tb_audio_agc_hang_attack;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;
    localparam int RAND_PHASES = 13;
    localparam int PHASE_WORDS = 130;
    localparam logic [agc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [agc_pkg::GAIN_W-1:0]    DATA_ALL  = '1;

    typedef struct packed {
        logic signed [agc_pkg::SAMPLE_W-1:0] sample;
        logic [agc_pkg::GAIN_W-1:0]          gain;
    } t_agc_word;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic signed [agc_pkg::SAMPLE_W-1:0]  i_sample_in;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic signed [agc_pkg::SAMPLE_W-1:0]  o_sample_out;
    logic [agc_pkg::GAIN_W-1:0]           o_gain_now;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [agc_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [agc_pkg::GAIN_W-1:0]           i_cfg_data;

    // predictor settings and state
    logic [agc_pkg::LVL_W-1:0]   ref_level_q;
    logic [agc_pkg::RATE_W-1:0]  attack_q;
    logic [agc_pkg::RATE_W-1:0]  decay_q;
    logic [agc_pkg::GAIN_W-1:0]  max_gain_q;
    logic [agc_pkg::CNT_W-1:0]   hang_len_q;
    logic [agc_pkg::CNT_W-1:0]   wait_len_q;
    logic [agc_pkg::ALPHA_W-1:0] alpha_q;
    logic [agc_pkg::GAIN_W-1:0]  gain_q;
    logic [agc_pkg::MAG_W-1:0]   peak_q;
    logic [agc_pkg::CNT_W-1:0]   hang_cnt_q;
    logic [agc_pkg::CNT_W-1:0]   wait_cnt_q;

    t_agc_word   gain_words_q[$];
    t_agc_word   head_w;
    int          fail_cnt;
    int unsigned cycle_cnt;
    int unsigned burst_left;
    bit          pace_gaps;
    int          env_amp;
    int          env_left;
    int unsigned rx_tick;
    int unsigned rx_mode;
    int unsigned rx_period;
    int unsigned rx_on;

    audio_agc_hang_attack dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_gain_now   (o_gain_now),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL audio_agc_hang_attack");
            $finish;
        end
    end

    function automatic void gain_model_reset();
        ref_level_q = agc_pkg::RST_REF_LEVEL;
        attack_q    = agc_pkg::RST_ATTACK;
        decay_q     = agc_pkg::RST_DECAY;
        max_gain_q  = agc_pkg::RST_MAX_GAIN;
        hang_len_q  = agc_pkg::RST_HANG;
        wait_len_q  = agc_pkg::RST_WAIT;
        alpha_q     = agc_pkg::RST_ALPHA;
        gain_q      = agc_pkg::GAIN_ONE;
        peak_q      = '0;
        hang_cnt_q  = '0;
        wait_cnt_q  = '0;
    endfunction

    // floor(v * r / 2^16), rounding toward minus infinity
    function automatic longint rate_floor(longint v, longint r);
        if (v >= 0)
            return (v * r) >>> 16;
        return -(((-v) * r + 65535) >>> 16);
    endfunction

    function automatic t_agc_word gain_predict(logic [agc_pkg::SAMPLE_W-1:0] raw);
        longint    mag;
        longint    gain;
        longint    ratio;
        longint    err;
        longint    delta;
        longint    alpha;
        longint    g;
        longint    q;
        t_agc_word w;
        mag  = raw[agc_pkg::SAMPLE_W-1] ? 65536 - longint'(raw) : longint'(raw);
        gain = longint'(gain_q);
        if (mag != 0) begin
            ratio = (longint'(ref_level_q) << 16) / mag;
            err   = ratio - gain;
            delta = 0;
            if (err < 0) begin
                if (longint'(peak_q) < mag) begin
                    wait_cnt_q = wait_len_q;
                    peak_q     = agc_pkg::MAG_W'(mag);
                end
                if (wait_cnt_q != 0) begin
                    wait_cnt_q--;
                end else begin
                    delta      = rate_floor(err, longint'(attack_q));
                    hang_cnt_q = hang_len_q;
                end
            end else if (hang_cnt_q != 0) begin
                hang_cnt_q--;
            end else begin
                delta = rate_floor(err, longint'(decay_q));
            end
            gain += delta;
        end
        if (gain > longint'(max_gain_q))
            gain = longint'(max_gain_q);
        if (gain < 0)
            gain = 0;
        alpha = (alpha_q > agc_pkg::ALPHA_ONE) ? longint'(agc_pkg::ALPHA_ONE)
                                               : longint'(alpha_q);
        g = gain + (((longint'(agc_pkg::GAIN_ONE) - alpha) * longint'(gain_q)) >>> 16);
        if (g > longint'(agc_pkg::GAIN_TOP))
            g = longint'(agc_pkg::GAIN_TOP);
        gain_q = agc_pkg::GAIN_W'(g);
        q = (g * mag) >>> 16;
        if (raw[agc_pkg::SAMPLE_W-1]) begin
            if (q > 32768)
                q = 32768;
            w.sample = agc_pkg::SAMPLE_W'(65536 - q);
        end else begin
            if (q > 32767)
                q = 32767;
            w.sample = agc_pkg::SAMPLE_W'(q);
        end
        w.gain = agc_pkg::GAIN_W'(g);
        return w;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gain_words_q.size() == 0) begin
                fail_cnt++;
                $error("unexpected word: sample_out %0d, gain_now %0d",
                       o_sample_out, o_gain_now);
            end else begin
                head_w = gain_words_q.pop_front();
                if (o_sample_out !== head_w.sample) begin
                    fail_cnt++;
                    $error("sample_out: expected %0d, got %0d",
                           head_w.sample, o_sample_out);
                end
                if (o_gain_now !== head_w.gain) begin
                    fail_cnt++;
                    $error("gain_now: expected %0d, got %0d",
                           head_w.gain, o_gain_now);
                end
            end
        end
    end

    // receiver stall pattern
    initial begin
        i_out_ready = 1'b0;
        rx_tick     = 0;
        forever begin
            @(negedge i_clk);
            if (rx_tick % 300 == 0) begin
                rx_mode   = $urandom_range(0, 3);
                rx_period = $urandom_range(2, 9);
                rx_on     = $urandom_range(1, rx_period - 1);
            end
            case (rx_mode)
                0: i_out_ready = 1'b1;
                1: i_out_ready = (rx_tick % rx_period) < rx_on;
                2: i_out_ready = $urandom_range(0, 3) != 0;
                default: i_out_ready = (rx_tick % 64) < 40;
            endcase
            rx_tick++;
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic push_word(input logic [agc_pkg::SAMPLE_W-1:0] x);
        i_in_valid  = 1'b1;
        i_sample_in = x;
        do @(posedge i_clk); while (!o_in_ready);
        gain_words_q.push_back(gain_predict(x));
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [agc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [agc_pkg::GAIN_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            agc_pkg::CFG_REF_LEVEL: ref_level_q = data[agc_pkg::LVL_W-1:0];
            agc_pkg::CFG_ATTACK:    attack_q    = data[agc_pkg::RATE_W-1:0];
            agc_pkg::CFG_DECAY:     decay_q     = data[agc_pkg::RATE_W-1:0];
            agc_pkg::CFG_MAX_GAIN:  max_gain_q  = data;
            agc_pkg::CFG_HANG:      hang_len_q  = data[agc_pkg::CNT_W-1:0];
            agc_pkg::CFG_WAIT:      wait_len_q  = data[agc_pkg::CNT_W-1:0];
            agc_pkg::CFG_ALPHA:     alpha_q     = data[agc_pkg::ALPHA_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (gain_words_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (pace_gaps) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70)
                                                  : $urandom_range(0, 6);
                if (gap != 0) begin
                    i_in_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
        burst_left--;
    endtask

    // mostly envelope segments of random level and length, some noise and silence
    function automatic logic [agc_pkg::SAMPLE_W-1:0] next_sample();
        int unsigned pick = $urandom_range(0, 99);
        int          m;
        if (pick < 8)
            return agc_pkg::SAMPLE_W'($urandom);
        if (pick < 13)
            return '0;
        if (env_left == 0) begin
            env_left = $urandom_range(4, 80);
            env_amp  = 1 << $urandom_range(0, 14);
            env_amp  = env_amp + $urandom_range(0, env_amp);
            if (env_amp > 32767)
                env_amp = 32767;
        end
        env_left--;
        m = $urandom_range(env_amp / 2, env_amp);
        return $urandom_range(0, 1) ? agc_pkg::SAMPLE_W'(-m) : agc_pkg::SAMPLE_W'(m);
    endfunction

    function automatic logic [agc_pkg::GAIN_W-1:0] cfg_pick(longint unsigned top,
                                                            longint unsigned rst,
                                                            longint unsigned lo,
                                                            longint unsigned hi,
                                                            int width);
        longint unsigned v;
        longint unsigned junk;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = top;
            2: v = rst;
            default: v = lo + ({$urandom, $urandom} % (hi - lo + 1));
        endcase
        // stray bits above the register width must be ignored
        junk = ($urandom_range(0, 3) == 0) ? ({$urandom, $urandom} << width) : 0;
        return agc_pkg::GAIN_W'(v | junk);
    endfunction

    task automatic set_phase_config(input int p);
        if (p == 0) begin
            write_reg(agc_pkg::CFG_REF_LEVEL, '0);
            write_reg(agc_pkg::CFG_ATTACK, '0);
            write_reg(agc_pkg::CFG_DECAY, '0);
            write_reg(agc_pkg::CFG_MAX_GAIN, '0);
            write_reg(agc_pkg::CFG_HANG, '0);
            write_reg(agc_pkg::CFG_WAIT, '0);
            write_reg(agc_pkg::CFG_ALPHA, '0);
        end else if (p == 1) begin
            write_reg(agc_pkg::CFG_REF_LEVEL, 33'd32767);
            write_reg(agc_pkg::CFG_ATTACK, 33'd65535);
            write_reg(agc_pkg::CFG_DECAY, 33'd65535);
            write_reg(agc_pkg::CFG_MAX_GAIN, DATA_ALL);
            write_reg(agc_pkg::CFG_HANG, 33'd32767);
            write_reg(agc_pkg::CFG_WAIT, 33'd32767);
            write_reg(agc_pkg::CFG_ALPHA, 33'd131071);
        end else begin
            write_reg(agc_pkg::CFG_REF_LEVEL,
                      cfg_pick(32767, agc_pkg::RST_REF_LEVEL, 500, 32767, agc_pkg::LVL_W));
            write_reg(agc_pkg::CFG_ATTACK,
                      cfg_pick(65535, agc_pkg::RST_ATTACK, 0, 65535, agc_pkg::RATE_W));
            write_reg(agc_pkg::CFG_DECAY,
                      cfg_pick(65535, agc_pkg::RST_DECAY, 0, 4000, agc_pkg::RATE_W));
            write_reg(agc_pkg::CFG_MAX_GAIN,
                      cfg_pick(DATA_ALL, agc_pkg::GAIN_TOP, 65536, 64'd1 << 22,
                               agc_pkg::GAIN_W));
            write_reg(agc_pkg::CFG_HANG,
                      cfg_pick(32767, agc_pkg::RST_HANG, 0, 60, agc_pkg::CNT_W));
            write_reg(agc_pkg::CFG_WAIT,
                      cfg_pick(32767, agc_pkg::RST_WAIT, 0, 20, agc_pkg::CNT_W));
            write_reg(agc_pkg::CFG_ALPHA,
                      cfg_pick(131071, agc_pkg::RST_ALPHA, 40000, 131071, agc_pkg::ALPHA_W));
        end
    endtask

    // new peaks only happen while the peak is still low, so this runs first
    task automatic test_attack_wait();
        logic [agc_pkg::SAMPLE_W-1:0] seq [8] = '{16'd2000, 16'd2000, 16'd2000, 16'd6000,
                                                   -16'sd6000, 16'd6000, 16'd100, 16'd100};
        write_reg(agc_pkg::CFG_WAIT, 33'd3);
        write_reg(agc_pkg::CFG_HANG, 33'd2);
        write_reg(agc_pkg::CFG_ATTACK, 33'd65535);
        foreach (seq[i])
            push_word(seq[i]);
        drain();
    endtask

    task automatic test_field_extremes();
        logic [agc_pkg::SAMPLE_W-1:0] seq [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                                                   16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000};
        write_reg(agc_pkg::CFG_HANG, agc_pkg::RST_HANG);
        write_reg(agc_pkg::CFG_WAIT, agc_pkg::RST_WAIT);
        write_reg(agc_pkg::CFG_ATTACK, agc_pkg::RST_ATTACK);
        foreach (seq[i])
            push_word(seq[i]);
        drain();
    endtask

    task automatic test_gain_limits();
        write_reg(agc_pkg::CFG_REF_LEVEL, 33'd32767);
        write_reg(agc_pkg::CFG_DECAY, 33'd65535);
        write_reg(agc_pkg::CFG_HANG, '0);
        write_reg(agc_pkg::CFG_MAX_GAIN, 33'd70000);
        push_word(16'h0001);
        push_word(16'hFFFF);
        push_word(16'h0001);
        drain();
        // no smoothing loss: the filtered gain runs into its ceiling
        write_reg(agc_pkg::CFG_MAX_GAIN, agc_pkg::GAIN_TOP);
        write_reg(agc_pkg::CFG_ALPHA, '0);
        repeat (3) push_word(16'h0001);
        drain();
        write_reg(agc_pkg::CFG_ALPHA, 33'd131071);
        push_word(16'h0001);
        push_word(16'h0000);
        drain();
        write_reg(agc_pkg::CFG_REF_LEVEL, '0);
        write_reg(agc_pkg::CFG_ATTACK, 33'd65535);
        push_word(16'h7FFF);
        drain();
        write_reg(CFG_SPARE, DATA_ALL);
    endtask

    task automatic test_pause_until_empty();
        pace_gaps = 1'b0;
        repeat (30) begin
            pace();
            push_word(next_sample());
        end
        drain();
        repeat (30) begin
            pace();
            push_word(next_sample());
        end
        drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            set_phase_config(p);
            pace_gaps = (p % 4) != 1;
            repeat (PHASE_WORDS) begin
                pace();
                push_word(next_sample());
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fail_cnt    = 0;
        cycle_cnt   = 0;
        burst_left  = 0;
        pace_gaps   = 1'b1;
        env_amp     = 1;
        env_left    = 0;
        gain_model_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_attack_wait();
        test_field_extremes();
        test_gain_limits();
        test_pause_until_empty();
        test_random_phases();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASS audio_agc_hang_attack");
        else
            $display("FAIL audio_agc_hang_attack");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/agc_pkg.sv
sv/agc_mul.sv
sv/agc_dp.sv
sv/agc_ctrl.sv
sv/audio_agc_hang_attack.sv
sv/agc_chk.sv
tb/tb_audio_agc_hang_attack.sv
